// ===== rtl/tap_tempo_estimator_macros.svh =====
// Assertion macros for the tap tempo estimator.
// Used by the top level only; no other dependencies.
`ifndef TAP_TEMPO_ESTIMATOR_MACROS_SVH
`define TAP_TEMPO_ESTIMATOR_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define TTE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define TTE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tte_pkg.sv =====
// Package for the tap tempo estimator: widths, codes, types and helpers.
// No dependencies; used by every module of the block.
package tte_pkg;

   localparam int TIME_WIDTH  = 32;
   localparam int COUNT_WIDTH = 16;

   localparam int IN_TIME_W = 32;
   localparam int BPM_W     = 16;
   localparam int TAPS_W    = 16;
   localparam int STATUS_W  = 3;
   localparam int TOL_W     = 10;
   localparam int REQ_W     = 48;
   localparam int RSP_W     = 40;
   localparam int RSP_USED  = STATUS_W + BPM_W + TAPS_W;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_STRICT_TOL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOSE_TOL  = 1'b1;
   localparam logic [TOL_W-1:0] STRICT_TOL_RESET = 10'd30;
   localparam logic [TOL_W-1:0] LOOSE_TOL_RESET  = 10'd50;

   localparam int MS_PER_MIN = 60000;
   localparam int MSPM_W     = 16;
   localparam int NUM_W      = COUNT_WIDTH + MSPM_W;
   localparam int DM_W       = TIME_WIDTH + COUNT_WIDTH;
   localparam int TM_W       = TOL_W + COUNT_WIDTH;
   localparam int CMP_W      = DM_W + 1;
   localparam int REM_W      = TIME_WIDTH + 1;
   localparam int DIV_CNT_W  = $clog2(NUM_W);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [BPM_W-1:0]       BPM_MAX   = {BPM_W{1'b1}};
   localparam logic [TAPS_W-1:0]      TAPS_MAX  = {TAPS_W{1'b1}};

   localparam logic [STATUS_W-1:0] STATUS_FIRST     = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_RESTART   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_WAITING   = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NEW_BPM   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_SAME_BPM  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MULT,
      ST_JUDGE,
      ST_DIV,
      ST_ROUND,
      ST_FINISH
   } tte_state_type;

   typedef struct packed {
      logic load;
      logic mult;
      logic judge;
      logic div_step;
      logic round;
      logic out_load;
   } tte_cmd_type;

   typedef struct packed {
      logic to_div;
      logic div_last;
   } tte_sts_type;

   // |d - span/m| > tol, as d*m against span +- tol*m
   function automatic logic strays(input logic [CMP_W-1:0] dm,
                                   input logic [CMP_W-1:0] span,
                                   input logic [CMP_W-1:0] tm);
      logic above;
      logic below;
      above = dm > (span + tm);
      below = (tm <= span) && (dm < (span - tm));
      return above || below;
   endfunction

endpackage

// ===== rtl/tte_ctrl.sv =====
// Controller for the tap tempo estimator: sequences one tap at a time.
// Depends on tte_pkg; drives tte_datapath through command/status structs.
module tte_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  tte_pkg::tte_sts_type sts,
   output tte_pkg::tte_cmd_type cmd
);

   tte_pkg::tte_state_type state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tte_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         tte_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = tte_pkg::ST_MULT;
            end
         end
         tte_pkg::ST_MULT: begin
            cmd.mult = 1'b1;
            state_in = tte_pkg::ST_JUDGE;
         end
         tte_pkg::ST_JUDGE: begin
            cmd.judge = 1'b1;
            state_in  = sts.to_div ? tte_pkg::ST_DIV : tte_pkg::ST_FINISH;
         end
         tte_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = tte_pkg::ST_ROUND;
            end
         end
         tte_pkg::ST_ROUND: begin
            cmd.round = 1'b1;
            state_in  = tte_pkg::ST_FINISH;
         end
         tte_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = tte_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tte_pkg::ST_IDLE;
         end
      endcase

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/tte_datapath.sv =====
// Datapath for the tap tempo estimator: run state, tolerance registers,
// stray test, radix-2 divider, rounding and result register. Uses tte_pkg.
module tte_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [tte_pkg::REQ_W-1:0]         req_tdata,
   input  logic                              csr_wen,
   input  logic [tte_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tte_pkg::TOL_W-1:0]         csr_wdata,
   input  tte_pkg::tte_cmd_type              cmd,
   output tte_pkg::tte_sts_type              sts,
   output logic [tte_pkg::RSP_W-1:0]         rsp_tdata
);

   localparam int TW  = tte_pkg::TIME_WIDTH;
   localparam int CW  = tte_pkg::COUNT_WIDTH;
   localparam int NW  = tte_pkg::NUM_W;
   localparam int XW  = tte_pkg::CMP_W;

   logic [tte_pkg::TOL_W-1:0]    strict_ff, strict_in, loose_ff, loose_in;
   logic [CW-1:0]                count_ff, count_in, cnt_ff, cnt_in;
   logic [TW-1:0]                start_ff, start_in, prev_ff, prev_in;
   logic [TW-1:0]                t_ff, t_in, d_ff, d_in, span_ff, span_in;
   logic [tte_pkg::BPM_W-1:0]    cur_ff, cur_in;
   logic [tte_pkg::DM_W-1:0]     dm_ff, dm_in;
   logic [tte_pkg::TM_W-1:0]     tm_ff, tm_in;
   logic [NW-1:0]                quo_ff, quo_in;
   logic [tte_pkg::REM_W-1:0]    rem_ff, rem_in;
   logic [tte_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [tte_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [tte_pkg::BPM_W-1:0]    bpm_ff, bpm_in;
   logic [tte_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [tte_pkg::BPM_W-1:0]    rsp_bpm_ff, rsp_bpm_in;
   logic [tte_pkg::TAPS_W-1:0]   rsp_taps_ff, rsp_taps_in;

   logic [TW-1:0]             t_req;
   logic [CW-1:0]             m;
   logic                      first, stray_l, stray_s, restart;
   logic [tte_pkg::REM_W-1:0] shifted;
   logic                      fits;
   logic [TW-1:0]             r;
   logic                      round_up;
   logic [NW:0]               q_round;
   logic [tte_pkg::BPM_W-1:0] bpm_est;

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff <= tte_pkg::STRICT_TOL_RESET;
         loose_ff  <= tte_pkg::LOOSE_TOL_RESET;
         count_ff  <= '0;
         start_ff  <= '0;
         prev_ff   <= '0;
      end else begin
         strict_ff <= strict_in;
         loose_ff  <= loose_in;
         count_ff  <= count_in;
         start_ff  <= start_in;
         prev_ff   <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff          <= t_in;
      cur_ff        <= cur_in;
      cnt_ff        <= cnt_in;
      d_ff          <= d_in;
      span_ff       <= span_in;
      dm_ff         <= dm_in;
      tm_ff         <= tm_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      div_cnt_ff    <= div_cnt_in;
      status_ff     <= status_in;
      bpm_ff        <= bpm_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bpm_ff    <= rsp_bpm_in;
      rsp_taps_ff   <= rsp_taps_in;
   end

   always_comb begin
      t_req   = TW'(req_tdata[tte_pkg::IN_TIME_W-1:0]);
      m       = cnt_ff - CW'(1);
      first   = cnt_ff == CW'(1);
      stray_l = tte_pkg::strays(XW'(dm_ff), XW'(span_ff), XW'(tm_ff));
      stray_s = (cnt_ff == CW'(2))
                && tte_pkg::strays(XW'(dm_ff), XW'(span_ff), XW'(strict_ff));
      restart = !first && (stray_l || stray_s);

      sts.to_div   = !first && !restart && (cnt_ff > CW'(2));
      sts.div_last = div_cnt_ff == tte_pkg::DIV_CNT_W'(NW - 1);

      shifted = {rem_ff[TW-1:0], quo_ff[NW-1]};
      fits    = shifted >= {1'b0, span_ff};

      r        = rem_ff[TW-1:0];
      round_up = r >= (span_ff - r);
      q_round  = (NW+1)'(quo_ff) + (NW+1)'(round_up);
      if (span_ff == '0 || q_round > (NW+1)'(tte_pkg::BPM_MAX)) begin
         bpm_est = tte_pkg::BPM_MAX;
      end else begin
         bpm_est = q_round[tte_pkg::BPM_W-1:0];
      end

      strict_in     = strict_ff;
      loose_in      = loose_ff;
      count_in      = count_ff;
      start_in      = start_ff;
      prev_in       = prev_ff;
      t_in          = t_ff;
      cur_in        = cur_ff;
      cnt_in        = cnt_ff;
      d_in          = d_ff;
      span_in       = span_ff;
      dm_in         = dm_ff;
      tm_in         = tm_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      div_cnt_in    = div_cnt_ff;
      status_in     = status_ff;
      bpm_in        = bpm_ff;
      rsp_status_in = rsp_status_ff;
      rsp_bpm_in    = rsp_bpm_ff;
      rsp_taps_in   = rsp_taps_ff;

      if (csr_wen) begin
         case (csr_index)
            tte_pkg::CSR_STRICT_TOL: strict_in = csr_wdata;
            tte_pkg::CSR_LOOSE_TOL:  loose_in  = csr_wdata;
            default: ;
         endcase
      end

      if (cmd.load) begin
         t_in    = t_req;
         cur_in  = req_tdata[tte_pkg::IN_TIME_W +: tte_pkg::BPM_W];
         cnt_in  = (count_ff == tte_pkg::COUNT_MAX) ? count_ff : count_ff + CW'(1);
         d_in    = t_req - prev_ff;
         span_in = t_req - start_ff;
      end

      if (cmd.mult) begin
         dm_in  = tte_pkg::DM_W'(d_ff) * tte_pkg::DM_W'(m);
         tm_in  = tte_pkg::TM_W'(loose_ff) * tte_pkg::TM_W'(m);
         quo_in = NW'(tte_pkg::MS_PER_MIN) * NW'(m);
      end

      if (cmd.judge) begin
         prev_in    = t_ff;
         rem_in     = '0;
         div_cnt_in = '0;
         bpm_in     = '0;
         if (first) begin
            start_in  = t_ff;
            count_in  = cnt_ff;
            status_in = tte_pkg::STATUS_FIRST;
         end else if (restart) begin
            start_in  = t_ff;
            count_in  = CW'(1);
            status_in = tte_pkg::STATUS_RESTART;
         end else begin
            count_in  = cnt_ff;
            status_in = tte_pkg::STATUS_WAITING;
         end
      end

      if (cmd.div_step) begin
         rem_in     = fits ? shifted - {1'b0, span_ff} : shifted;
         quo_in     = {quo_ff[NW-2:0], fits};
         div_cnt_in = div_cnt_ff + tte_pkg::DIV_CNT_W'(1);
      end

      if (cmd.round) begin
         bpm_in    = bpm_est;
         status_in = (bpm_est != cur_ff) ? tte_pkg::STATUS_NEW_BPM
                                         : tte_pkg::STATUS_SAME_BPM;
      end

      if (cmd.out_load) begin
         rsp_status_in = status_ff;
         rsp_bpm_in    = bpm_ff;
         rsp_taps_in   = (tte_pkg::RSP_W'(count_ff) > tte_pkg::RSP_W'(tte_pkg::TAPS_MAX))
                         ? tte_pkg::TAPS_MAX : tte_pkg::TAPS_W'(count_ff);
      end
   end

   assign rsp_tdata = {{(tte_pkg::RSP_W - tte_pkg::RSP_USED){1'b0}},
                       rsp_taps_ff, rsp_bpm_ff, rsp_status_ff};

endmodule

// ===== rtl/tap_tempo_estimator.sv =====
// Top level of the tap tempo estimator: controller plus datapath.
// Depends on tte_pkg, tte_ctrl, tte_datapath and the assertion macro header.
`include "tap_tempo_estimator_macros.svh"

// Takes one tap per transaction and returns one result per tap. A tap that
// needs a tempo estimate passes through multiply, judge, 32 steps of the
// radix-2 divider, round and result load before the result is offered; first
// taps, restarts and second taps pass through multiply, judge and result load
// only. The block is ready again in the cycle after the result load. A new tap
// is taken as soon as the previous one is in the result register, even if that
// result has not been collected yet; the result load waits while an earlier
// result is still uncollected. Tolerance registers may be written only while
// the block is idle.
module tap_tempo_estimator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [tte_pkg::REQ_W-1:0]     req_tdata,   // tap_time_ms, current_bpm
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [tte_pkg::RSP_W-1:0]     rsp_tdata,   // tap_status, bpm, taps_in_run
   input  logic                          csr_wen,
   input  logic [tte_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tte_pkg::TOL_W-1:0]     csr_wdata
);

   tte_pkg::tte_cmd_type cmd;
   tte_pkg::tte_sts_type sts;

   tte_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   tte_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata)
   );

   `TTE_ASSERT_NEXT(a_one_tap_at_a_time, clock, reset,
      req_tvalid && req_tready, !req_tready, "tap accepted while another in work")

   `TTE_ASSERT_NOW(a_restart_count_one, clock, reset,
      rsp_tvalid && (rsp_tdata[2:0] == tte_pkg::STATUS_FIRST
                     || rsp_tdata[2:0] == tte_pkg::STATUS_RESTART),
      rsp_tdata[34:19] == 16'd1, "first or restarted tap with count not one")

   `TTE_ASSERT_NOW(a_no_bpm_without_estimate, clock, reset,
      rsp_tvalid && (rsp_tdata[2:0] == tte_pkg::STATUS_FIRST
                     || rsp_tdata[2:0] == tte_pkg::STATUS_RESTART
                     || rsp_tdata[2:0] == tte_pkg::STATUS_WAITING),
      rsp_tdata[18:3] == 16'd0, "bpm non-zero without an estimate")

endmodule
